### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the quaternion vector rotator.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define QVR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define QVR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/qvr_pkg.sv
// Package for the quaternion vector rotator: fixed widths, action codes,
// pipeline stage count and the stage advance struct. No dependencies.
`default_nettype none

package qvr_pkg;

    localparam int QUAT_WIDTH  = 16;
    localparam int QPROD_WIDTH = 2 * QUAT_WIDTH;
    // Diagonal entries reach 2^31 in magnitude, off-diagonals 2^32.
    localparam int ENTRY_WIDTH = QPROD_WIDTH + 2;
    localparam int NUM_STAGES  = 5;

    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [QPROD_WIDTH-1:0] qprod_t;
    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

    localparam logic ACT_BODY_TO_WORLD = 1'b0;
    localparam logic ACT_WORLD_TO_BODY = 1'b1;

    // Load enables of the dot-product stages.
    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic out_en;
    } qvr_adv_t;

endpackage

`default_nettype wire

### rtl/qvr_dot3.sv
// One rotated component: three matrix-by-vector products, their sum with
// rounding, and saturation. Three register stages. Depends on qvr_pkg.
`default_nettype none

module qvr_dot3 #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int VEC_WIDTH      = 24
) (
    input  wire                          clk,
    input  qvr_pkg::qvr_adv_t            adv,
    input  qvr_pkg::entry_t              m1,
    input  qvr_pkg::entry_t              m2,
    input  qvr_pkg::entry_t              m3,
    input  wire logic signed [VEC_WIDTH-1:0] v1,
    input  wire logic signed [VEC_WIDTH-1:0] v2,
    input  wire logic signed [VEC_WIDTH-1:0] v3,
    output logic        [VEC_WIDTH-1:0]  rot,
    output logic                         clip
);
    import qvr_pkg::*;

    localparam int PW   = ENTRY_WIDTH + VEC_WIDTH;
    localparam int SUMW = PW + 3;
    localparam int SH   = 2 * QUAT_FRAC_BITS;
    localparam int ACCW = (SUMW > SH + 2) ? SUMW : SH + 2;

    localparam logic signed [ACCW-1:0] HALF =
        {{(ACCW - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
    localparam logic [VEC_WIDTH-1:0] MAXV = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic [VEC_WIDTH-1:0] MINV = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    logic signed [PW-1:0]   p1_reg, p2_reg, p3_reg;
    logic signed [PW-1:0]   p1_next, p2_next, p3_next;
    logic signed [ACCW-1:0] sum_reg, sum_next;
    logic signed [ACCW-1:0] shifted;
    logic                   in_range;
    logic [VEC_WIDTH-1:0]   rot_reg, rot_next;
    logic                   clip_reg, clip_next;

    assign p1_next = m1 * v1;
    assign p2_next = m2 * v2;
    assign p3_next = m3 * v3;

    assign sum_next = ACCW'(p1_reg) + ACCW'(p2_reg) + ACCW'(p3_reg) + HALF;

    // Round half up: the half was added above, the shift floors.
    always_comb
    begin
        shifted   = sum_reg >>> SH;
        in_range  = (&shifted[ACCW-1:VEC_WIDTH-1]) || !(|shifted[ACCW-1:VEC_WIDTH-1]);
        clip_next = !in_range;
        if (in_range)
        begin
            rot_next = shifted[VEC_WIDTH-1:0];
        end
        else if (shifted[ACCW-1])
        begin
            rot_next = MINV;
        end
        else
        begin
            rot_next = MAXV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul_en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
        if (adv.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (adv.out_en)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign rot  = rot_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

### rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotator: quaternion products, matrix
// build with optional transpose, and three dot-product lanes.
// Depends on qvr_pkg, qvr_dot3 and assert_macros.svh.
//
// Usage. Each slave transfer carries one attitude quaternion (w, i, j, k,
// signed with QUAT_FRAC_BITS fraction bits) and one signed vector (a, b, c)
// in s_axis_tdata, and the action in s_axis_tuser: 0 rotates a body-frame
// vector into the world frame, 1 rotates a world-frame vector into the body
// frame with the transposed matrix. The quaternion is not normalized, so the
// result scales with its squared norm. Each master transfer returns the three
// rotated components, rounded half up and saturated to VEC_WIDTH bits, in
// m_axis_tdata, and in m_axis_tuser a flag that is set when any component
// was clipped. Exactly one result leaves for each accepted item, in order.
// There are five register stages: product, matrix, multiply, sum and
// round/saturate. An accepted item passes through them in that order, and
// m_axis_tvalid is high while the round/saturate stage holds an item. One
// item is taken every clock cycle while the receiver
// keeps up. When the receiver stalls, the results wait in the pipeline; empty
// stages still fill, so s_axis_tready drops only once all five stages hold an
// item. Reset empties the pipeline and keeps no other state.
`default_nettype none
`include "assert_macros.svh"

module quaternion_vector_rotate #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int VEC_WIDTH      = 24
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // quat_w, quat_i, quat_j, quat_k, vec_a, vec_b, vec_c, zero padding
    input  wire [((4 * qvr_pkg::QUAT_WIDTH + 3 * VEC_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  wire                   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // rot_a, rot_b, rot_c, zero padding
    output logic [((3 * VEC_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // clipped
    output logic                  m_axis_tuser
);
    import qvr_pkg::*;

    localparam int QBITS = 4 * QUAT_WIDTH;
    localparam int MBITS = 3 * VEC_WIDTH;
    localparam int MW    = ((MBITS + 7) / 8) * 8;

    typedef logic signed [VEC_WIDTH-1:0] vec_t;

    // Stage valids and the per-stage ready chain.
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] ready;
    logic [NUM_STAGES-1:0] load;

    // Stage 0: quaternion products.
    quat_t  qw, qi, qj, qk;
    qprod_t ww_reg, ii_reg, jj_reg, kk_reg, ij_reg, kw_reg, ik_reg, jw_reg, jk_reg, iw_reg;
    qprod_t ww_next, ii_next, jj_next, kk_next, ij_next, kw_next, ik_next, jw_next;
    qprod_t jk_next, iw_next;
    logic   act0_reg;
    vec_t   vec0_reg [3];

    // Stage 1: matrix rows in the order the lanes need them.
    entry_t mat [3][3];
    entry_t row_reg [3][3];
    entry_t row_next [3][3];
    vec_t   vec1_reg [3];

    qvr_adv_t              adv;
    logic [VEC_WIDTH-1:0]  rot [3];
    logic [2:0]            clip;

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
        valid_next[0] = ready[0] ? s_axis_tvalid : valid_reg[0];
        load[0]       = ready[0] && s_axis_tvalid;
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            valid_next[s] = ready[s] ? valid_reg[s-1] : valid_reg[s];
            load[s]       = ready[s] && valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];

    // Stage 0: ten pairwise products of the quaternion parts.
    assign qw = s_axis_tdata[0*QUAT_WIDTH +: QUAT_WIDTH];
    assign qi = s_axis_tdata[1*QUAT_WIDTH +: QUAT_WIDTH];
    assign qj = s_axis_tdata[2*QUAT_WIDTH +: QUAT_WIDTH];
    assign qk = s_axis_tdata[3*QUAT_WIDTH +: QUAT_WIDTH];

    assign ww_next = qw * qw;
    assign ii_next = qi * qi;
    assign jj_next = qj * qj;
    assign kk_next = qk * qk;
    assign ij_next = qi * qj;
    assign kw_next = qk * qw;
    assign ik_next = qi * qk;
    assign jw_next = qj * qw;
    assign jk_next = qj * qk;
    assign iw_next = qi * qw;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            ww_reg   <= ww_next;
            ii_reg   <= ii_next;
            jj_reg   <= jj_next;
            kk_reg   <= kk_next;
            ij_reg   <= ij_next;
            kw_reg   <= kw_next;
            ik_reg   <= ik_next;
            jw_reg   <= jw_next;
            jk_reg   <= jk_next;
            iw_reg   <= iw_next;
            act0_reg <= s_axis_tuser;
            for (int n = 0; n < 3; n++)
            begin
                vec0_reg[n] <= s_axis_tdata[QBITS + n*VEC_WIDTH +: VEC_WIDTH];
            end
        end
    end

    // Stage 1: direction-cosine matrix, exact, then the transpose select.
    always_comb
    begin
        mat[0][0] = ENTRY_WIDTH'(ii_reg) + ENTRY_WIDTH'(ww_reg)
                  - ENTRY_WIDTH'(jj_reg) - ENTRY_WIDTH'(kk_reg);
        mat[1][1] = ENTRY_WIDTH'(jj_reg) + ENTRY_WIDTH'(ww_reg)
                  - ENTRY_WIDTH'(ii_reg) - ENTRY_WIDTH'(kk_reg);
        mat[2][2] = ENTRY_WIDTH'(kk_reg) + ENTRY_WIDTH'(ww_reg)
                  - ENTRY_WIDTH'(ii_reg) - ENTRY_WIDTH'(jj_reg);
        mat[0][1] = (ENTRY_WIDTH'(ij_reg) - ENTRY_WIDTH'(kw_reg)) <<< 1;
        mat[0][2] = (ENTRY_WIDTH'(ik_reg) + ENTRY_WIDTH'(jw_reg)) <<< 1;
        mat[1][0] = (ENTRY_WIDTH'(ij_reg) + ENTRY_WIDTH'(kw_reg)) <<< 1;
        mat[1][2] = (ENTRY_WIDTH'(jk_reg) - ENTRY_WIDTH'(iw_reg)) <<< 1;
        mat[2][0] = (ENTRY_WIDTH'(ik_reg) - ENTRY_WIDTH'(jw_reg)) <<< 1;
        mat[2][1] = (ENTRY_WIDTH'(jk_reg) + ENTRY_WIDTH'(iw_reg)) <<< 1;

        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                unique case (act0_reg)
                    ACT_BODY_TO_WORLD: row_next[r][c] = mat[r][c];
                    ACT_WORLD_TO_BODY: row_next[r][c] = mat[c][r];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            row_reg  <= row_next;
            vec1_reg <= vec0_reg;
        end
    end

    // Stages 2 to 4 live in the lanes.
    assign adv.mul_en = load[2];
    assign adv.sum_en = load[3];
    assign adv.out_en = load[4];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        qvr_dot3 #(
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
            .VEC_WIDTH      (VEC_WIDTH)
        ) u_dot3 (
            .clk  (clk),
            .adv  (adv),
            .m1   (row_reg[g][0]),
            .m2   (row_reg[g][1]),
            .m3   (row_reg[g][2]),
            .v1   (vec1_reg[0]),
            .v2   (vec1_reg[1]),
            .v3   (vec1_reg[2]),
            .rot  (rot[g]),
            .clip (clip[g])
        );
    end

    assign m_axis_tdata = MW'({rot[2], rot[1], rot[0]});
    assign m_axis_tuser = |clip;

    // The input stalls only when every stage holds an item.
    `QVR_ASSERT(a_stall_full, !s_axis_tready |-> (&valid_reg), "input stalled with a free stage")
    // An accepted item always lands in the first stage.
    `QVR_ASSERT(a_accept_lands, (s_axis_tvalid && s_axis_tready) |=> valid_reg[0],
        "accepted item lost at stage 0")
    // A clipped result sits at a bound of the signed range.
    `QVR_ASSERT(a_clip_bound, (m_axis_tvalid && m_axis_tuser) |->
        ((rot[0][VEC_WIDTH-2:0] == {(VEC_WIDTH-1){!rot[0][VEC_WIDTH-1]}}) ||
         (rot[1][VEC_WIDTH-2:0] == {(VEC_WIDTH-1){!rot[1][VEC_WIDTH-1]}}) ||
         (rot[2][VEC_WIDTH-2:0] == {(VEC_WIDTH-1){!rot[2][VEC_WIDTH-1]}})),
        "clip flag set with no component at a bound")
    // Once reset has been seen at an edge, the pipeline is empty at the next one.
    `QVR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (valid_reg == '0), "pipeline busy in reset")

endmodule

`default_nettype wire
